// File: rtl/tkck_pkg.sv
// Shared types, constants and state encoding for the top-k closest keeper.
package tkck_pkg;

    localparam int MaxKeepDefault = 64;
    localparam logic [31:0] CutoffReset = 32'd65536000;
    localparam logic [6:0] KeepLimitReset = 7'd64;

    localparam logic CfgKeepLimit = 1'b0;
    localparam logic CfgInitialCutoff = 1'b1;

    localparam logic FuncOffer = 1'b0;
    localparam logic FuncReport = 1'b1;

    // One stored record: distance plus five parameters.
    localparam int EntryWidth = 32 + 16 + 4 * 32;

    typedef struct packed {
        logic        func;
        logic        exploded;
        logic [31:0] distance;
        logic [15:0] root_length;
        logic [31:0] a_insert;
        logic [31:0] a_delete;
        logic [31:0] insert_ratio;
        logic [31:0] delete_ratio;
    } req_in_t;

    typedef struct packed {
        logic [15:0] mean_root_length;
        logic [31:0] mean_a_insert;
        logic [31:0] mean_a_delete;
        logic [31:0] mean_insert_ratio;
        logic [31:0] mean_delete_ratio;
        logic [6:0]  kept_count;
        logic [31:0] valid_runs;
    } req_out_t;

    typedef struct packed {
        logic [31:0] distance;
        logic [15:0] root_length;
        logic [31:0] a_insert;
        logic [31:0] a_delete;
        logic [31:0] insert_ratio;
        logic [31:0] delete_ratio;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_CUT_RD,
        ST_CUT_CHK,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// File: rtl/tkck_ram.sv
// Generic single-port synchronous RAM with registered read data.
module tkck_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/tkck_divider.sv
// Restoring divider shared by the five mean fields, one quotient bit per cycle.
module tkck_divider #(
    parameter int NumWidth = 48,
    parameter int DenWidth = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NumWidth-1:0] numer,
    input  logic [DenWidth-1:0] denom,
    output logic                busy,
    output logic [NumWidth-1:0] quot
);

    localparam int CntWidth = $clog2(NumWidth + 1);

    logic [NumWidth-1:0] quot_reg, quot_next;
    logic [DenWidth:0]   rem_reg, rem_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic [DenWidth:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        trial     = {rem_reg[DenWidth-1:0], quot_reg[NumWidth-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CntWidth'(NumWidth);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, denom})
            begin
                rem_next  = trial - {1'b0, denom};
                quot_next = {quot_reg[NumWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NumWidth-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

// File: rtl/top_k_closest_keeper_top.sv
// Top level of the top-k closest keeper: sorted list in RAM, insert and report sequencer.
// An offer below the cutoff scans up to its slot and shifts the entries above it,
// then places itself and, when the list overflows the limit, trims and updates the cutoff.
// Scan and shift share the single RAM port. An offer that misses the cutoff leaves the list as is.
// A report sums the kept entries, then runs five divisions on one shared divider, one
// after another, or none when the list is empty. One request is handled at a time.
// Reset empties the list, zeroes the run counter and loads the default limit and cutoff.
module top_k_closest_keeper_top #(
    parameter int MaxKeep = tkck_pkg::MaxKeepDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tkck_pkg::req_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tkck_pkg::req_out_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    // The RAM holds one extra staging slot above the kept entries.
    localparam int Depth    = MaxKeep + 1;
    localparam int AddrW    = $clog2(Depth);
    localparam int CntW     = $clog2(MaxKeep + 2);
    localparam int SumExtra = $clog2(MaxKeep + 1);
    localparam int NumW     = 32 + SumExtra;

    logic [6:0]  keep_limit_reg;
    logic [31:0] init_cutoff_reg;
    logic [31:0] cutoff_reg, cutoff_next;
    logic [31:0] runs_reg, runs_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic [CntW-1:0] idx_reg, idx_next;   // scan / shift pointer
    logic [CntW-1:0] pos_reg, pos_next;   // insert position
    tkck_pkg::state_t state_reg, state_next;
    tkck_pkg::req_in_t req_reg;
    logic [2:0]  field_reg, field_next;

    // Sums of the five parameter fields over the kept entries.
    logic [NumW-1:0] sum_reg [5];
    logic [NumW-1:0] sum_next [5];
    logic [31:0] mean_reg [5];
    logic [31:0] mean_next [5];

    tkck_pkg::req_out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic            ram_we;
    logic [AddrW-1:0] ram_addr;
    tkck_pkg::entry_t ram_wdata, ram_rdata;

    logic [CntW-1:0] lim_eff;
    logic            div_start, div_busy;
    logic [NumW-1:0] div_num, div_quot;
    logic [CntW-1:0] div_den;

    tkck_ram #(.Width(tkck_pkg::EntryWidth), .Depth(Depth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tkck_divider #(.NumWidth(NumW), .DenWidth(CntW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // A limit of zero acts as one, and limits above the storage clamp to it.
    always_comb
    begin
        if (keep_limit_reg == '0)
        begin
            lim_eff = CntW'(1);
        end
        else if (32'(keep_limit_reg) > 32'(MaxKeep))
        begin
            lim_eff = CntW'(MaxKeep);
        end
        else
        begin
            lim_eff = CntW'(keep_limit_reg);
        end
    end

    assign in_stall  = (state_reg != tkck_pkg::ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tkck_pkg::ST_IDLE;
            keep_limit_reg  <= tkck_pkg::KeepLimitReset;
            init_cutoff_reg <= tkck_pkg::CutoffReset;
            cutoff_reg      <= tkck_pkg::CutoffReset;
            runs_reg        <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            runs_reg      <= runs_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            cutoff_reg    <= cutoff_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tkck_pkg::CfgKeepLimit:
                    begin
                        keep_limit_reg <= cfg_data[6:0];
                    end
                    tkck_pkg::CfgInitialCutoff:
                    begin
                        init_cutoff_reg <= cfg_data;
                        cutoff_reg      <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            req_reg <= in_data;
        end
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        field_reg <= field_next;
        out_reg   <= out_next;
        for (int k = 0; k < 5; k++)
        begin
            sum_reg[k]  <= sum_next[k];
            mean_reg[k] <= mean_next[k];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        runs_next      = runs_reg;
        fill_next      = fill_reg;
        cutoff_next    = cutoff_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        field_next     = field_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_addr       = idx_reg[AddrW-1:0];
        ram_wdata      = ram_rdata;
        div_start      = 1'b0;
        div_num        = sum_reg[0];
        div_den        = fill_reg;
        for (int k = 0; k < 5; k++)
        begin
            sum_next[k]  = sum_reg[k];
            mean_next[k] = mean_reg[k];
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tkck_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid && !in_stall)
                begin
                    if (in_data.func == tkck_pkg::FuncReport)
                    begin
                        for (int k = 0; k < 5; k++)
                        begin
                            sum_next[k] = '0;
                        end
                        state_next = tkck_pkg::ST_SUM_RD;
                    end
                    else if (!in_data.exploded)
                    begin
                        if (runs_reg != '1)
                        begin
                            runs_next = runs_reg + 32'd1;
                        end
                        // The list only changes when an entry is inserted, so a lowered
                        // limit takes effect at the next insertion.
                        if (in_data.distance < cutoff_reg)
                        begin
                            state_next = tkck_pkg::ST_SEARCH_RD;
                        end
                    end
                end
            end
            // Linear scan for the first entry with a strictly greater distance.
            tkck_pkg::ST_SEARCH_RD:
            begin
                if (idx_reg >= fill_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = fill_reg;
                    state_next = tkck_pkg::ST_SHIFT_RD;
                end
                else
                begin
                    state_next = tkck_pkg::ST_SEARCH_CHK;
                end
            end
            tkck_pkg::ST_SEARCH_CHK:
            begin
                if (ram_rdata.distance > req_reg.distance)
                begin
                    pos_next   = idx_reg;
                    idx_next   = fill_reg;
                    state_next = tkck_pkg::ST_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = tkck_pkg::ST_SEARCH_RD;
                end
            end
            // Move entries up one slot from the tail down to the insert position.
            tkck_pkg::ST_SHIFT_RD:
            begin
                if (idx_reg <= pos_reg)
                begin
                    state_next = tkck_pkg::ST_PLACE;
                end
                else
                begin
                    ram_addr   = AddrW'(idx_reg - 1'b1);
                    state_next = tkck_pkg::ST_SHIFT_WR;
                end
            end
            tkck_pkg::ST_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = tkck_pkg::ST_SHIFT_RD;
            end
            tkck_pkg::ST_PLACE:
            begin
                ram_we    = 1'b1;
                ram_addr  = pos_reg[AddrW-1:0];
                ram_wdata = '{distance:     req_reg.distance,
                              root_length:  req_reg.root_length,
                              a_insert:     req_reg.a_insert,
                              a_delete:     req_reg.a_delete,
                              insert_ratio: req_reg.insert_ratio,
                              delete_ratio: req_reg.delete_ratio};
                if (fill_reg + 1'b1 > lim_eff)
                begin
                    fill_next  = lim_eff;
                    idx_next   = lim_eff - 1'b1;
                    state_next = tkck_pkg::ST_CUT_RD;
                end
                else
                begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = tkck_pkg::ST_IDLE;
                end
            end
            // After trimming, the cutoff becomes the distance of the new last entry.
            tkck_pkg::ST_CUT_RD:
            begin
                state_next = tkck_pkg::ST_CUT_CHK;
            end
            tkck_pkg::ST_CUT_CHK:
            begin
                cutoff_next = ram_rdata.distance;
                state_next  = tkck_pkg::ST_IDLE;
            end
            tkck_pkg::ST_SUM_RD:
            begin
                if (idx_reg >= fill_reg)
                begin
                    field_next = '0;
                    state_next = tkck_pkg::ST_DIV;
                end
                else
                begin
                    state_next = tkck_pkg::ST_SUM_ACC;
                end
            end
            tkck_pkg::ST_SUM_ACC:
            begin
                sum_next[0] = sum_reg[0] + NumW'(ram_rdata.root_length);
                sum_next[1] = sum_reg[1] + NumW'(ram_rdata.a_insert);
                sum_next[2] = sum_reg[2] + NumW'(ram_rdata.a_delete);
                sum_next[3] = sum_reg[3] + NumW'(ram_rdata.insert_ratio);
                sum_next[4] = sum_reg[4] + NumW'(ram_rdata.delete_ratio);
                idx_next    = idx_reg + 1'b1;
                state_next  = tkck_pkg::ST_SUM_RD;
            end
            // Start one division per field; an empty list skips straight to zero means.
            tkck_pkg::ST_DIV:
            begin
                if (fill_reg == '0)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        mean_next[k] = '0;
                    end
                    state_next = tkck_pkg::ST_OUT;
                end
                else
                begin
                    div_num    = sum_reg[field_reg];
                    div_start  = 1'b1;
                    state_next = tkck_pkg::ST_OUT;
                end
            end
            tkck_pkg::ST_OUT:
            begin
                if (fill_reg != '0 && div_busy)
                begin
                    state_next = tkck_pkg::ST_OUT;
                end
                else if (fill_reg != '0 && field_reg != 3'd5)
                begin
                    mean_next[field_reg] = div_quot[31:0];
                    field_next = field_reg + 3'd1;
                    if (field_reg != 3'd4)
                    begin
                        state_next = tkck_pkg::ST_DIV;
                    end
                    else
                    begin
                        field_next = 3'd5;
                    end
                end
                else
                begin
                    out_next.mean_root_length  = mean_reg[0][15:0];
                    out_next.mean_a_insert     = mean_reg[1];
                    out_next.mean_a_delete     = mean_reg[2];
                    out_next.mean_insert_ratio = mean_reg[3];
                    out_next.mean_delete_ratio = mean_reg[4];
                    out_next.kept_count        = 7'(fill_reg);
                    out_next.valid_runs        = runs_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = tkck_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkck_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CntW'(MaxKeep))
        else $error("fill count exceeds storage");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tkck_pkg::ST_IDLE) |-> in_stall)
        else $error("request accepted while busy");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tkck_pkg::ST_OUT))
        else $error("result raised outside report completion");
    a_cut_after_place: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkck_pkg::ST_CUT_RD) |-> $past(state_reg == tkck_pkg::ST_PLACE))
        else $error("trim without insertion");
`endif

endmodule

// File: test/top_k_closest_keeper_checker.sv
// Checker for the top-k closest keeper: predicts report results and compares them.
module top_k_closest_keeper_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  tkck_pkg::req_in_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  tkck_pkg::req_out_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    tkck_pkg::entry_t   kept_list [0:tkck_pkg::MaxKeepDefault];
    int unsigned        kept_fill;
    logic [6:0]         limit_reg;
    logic [31:0]        cutoff_reg;
    logic [31:0]        run_total;
    tkck_pkg::req_out_t expected_means [$];

    assign pending_reports = expected_means.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int unsigned effective_limit();
        if (limit_reg == 0)
            return 1;
        if (limit_reg > tkck_pkg::MaxKeepDefault)
            return tkck_pkg::MaxKeepDefault;
        return limit_reg;
    endfunction

    task automatic insert_offer(input tkck_pkg::req_in_t req);
        int unsigned pos;
        int unsigned lim;
        pos = 0;
        if (run_total != 32'hFFFF_FFFF)
            run_total++;
        if (req.distance >= cutoff_reg)
            return;
        while (pos < kept_fill && kept_list[pos].distance <= req.distance)
            pos++;
        for (int unsigned i = kept_fill; i > pos; i--)
            kept_list[i] = kept_list[i-1];
        kept_list[pos] = '{req.distance, req.root_length, req.a_insert, req.a_delete,
                           req.insert_ratio, req.delete_ratio};
        kept_fill++;
        lim = effective_limit();
        if (kept_fill > lim)
        begin
            kept_fill = lim;
            cutoff_reg = kept_list[lim-1].distance;
        end
    endtask

    function automatic tkck_pkg::req_out_t compute_means();
        logic [63:0] s_rl, s_ai, s_ad, s_ir, s_dr;
        tkck_pkg::req_out_t r;
        s_rl = 0; s_ai = 0; s_ad = 0; s_ir = 0; s_dr = 0;
        for (int unsigned i = 0; i < kept_fill; i++)
        begin
            s_rl += kept_list[i].root_length;
            s_ai += kept_list[i].a_insert;
            s_ad += kept_list[i].a_delete;
            s_ir += kept_list[i].insert_ratio;
            s_dr += kept_list[i].delete_ratio;
        end
        if (kept_fill != 0)
        begin
            s_rl /= kept_fill; s_ai /= kept_fill; s_ad /= kept_fill;
            s_ir /= kept_fill; s_dr /= kept_fill;
        end
        r.mean_root_length  = s_rl[15:0];
        r.mean_a_insert     = s_ai[31:0];
        r.mean_a_delete     = s_ad[31:0];
        r.mean_insert_ratio = s_ir[31:0];
        r.mean_delete_ratio = s_dr[31:0];
        r.kept_count        = kept_fill[6:0];
        r.valid_runs        = run_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_fill = 0;
            limit_reg = tkck_pkg::KeepLimitReset;
            cutoff_reg = tkck_pkg::CutoffReset;
            run_total = 0;
            fail_count = 0;
            expected_means.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tkck_pkg::CfgKeepLimit)
                    limit_reg = cfg_data[6:0];
                else
                    cutoff_reg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.func == tkck_pkg::FuncReport)
                    expected_means = {expected_means, compute_means()};
                else if (!in_data.exploded)
                    insert_offer(in_data);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch("unexpected result, kept_count",
                                    32'(out_data.kept_count), 32'd0);
                end
                else
                begin
                    tkck_pkg::req_out_t w;
                    w = expected_means.pop_front();
                    if (out_data.mean_root_length !== w.mean_root_length)
                        report_mismatch("mean_root_length", 32'(out_data.mean_root_length),
                                        32'(w.mean_root_length));
                    if (out_data.mean_a_insert !== w.mean_a_insert)
                        report_mismatch("mean_a_insert", out_data.mean_a_insert,
                                        w.mean_a_insert);
                    if (out_data.mean_a_delete !== w.mean_a_delete)
                        report_mismatch("mean_a_delete", out_data.mean_a_delete,
                                        w.mean_a_delete);
                    if (out_data.mean_insert_ratio !== w.mean_insert_ratio)
                        report_mismatch("mean_insert_ratio", out_data.mean_insert_ratio,
                                        w.mean_insert_ratio);
                    if (out_data.mean_delete_ratio !== w.mean_delete_ratio)
                        report_mismatch("mean_delete_ratio", out_data.mean_delete_ratio,
                                        w.mean_delete_ratio);
                    if (out_data.kept_count !== w.kept_count)
                        report_mismatch("kept_count", 32'(out_data.kept_count),
                                        32'(w.kept_count));
                    if (out_data.valid_runs !== w.valid_runs)
                        report_mismatch("valid_runs", out_data.valid_runs, w.valid_runs);
                end
            end
        end
    end

endmodule

// File: test/top_k_closest_keeper_top_tb.sv
// Testbench top for the top-k closest keeper: stimulus, configuration phases and verdict.
module top_k_closest_keeper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest request is a report, so the quiet-cycle watchdog is set far above
    // its duration plus the longest receiver stall streak.
    localparam int QuietLimit = 20000;
    localparam int DrainCycles = 600;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    tkck_pkg::req_in_t  in_data;
    logic               out_valid;
    logic               out_stall;
    tkck_pkg::req_out_t out_data;
    logic               cfg_we;
    logic               cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending_reports;

    // Idle rates in percent for the sender and the receiver.
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    top_k_closest_keeper_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    top_k_closest_keeper_checker result_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_reports(pending_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // The watchdog ends the run if no request moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Sends one request and holds it until it is taken. Random idle cycles come first.
    // Valid stays high after the accepting edge; the next call or stop_sending drops it.
    task automatic send_request(input tkck_pkg::req_in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // Waits until every expected result has come, then lets an offer still in
    // flight finish before the block is touched again.
    task automatic wait_idle();
        stop_sending();
        while (pending_reports != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tkck_pkg::req_in_t make_offer(input logic [31:0] dist_val,
                                                     input logic boom);
        tkck_pkg::req_in_t r;
        r.func         = tkck_pkg::FuncOffer;
        r.exploded     = boom;
        r.distance     = dist_val;
        r.root_length  = 16'($urandom);
        r.a_insert     = $urandom;
        r.a_delete     = $urandom;
        r.insert_ratio = $urandom;
        r.delete_ratio = $urandom;
        return r;
    endfunction

    function automatic tkck_pkg::req_in_t make_report();
        tkck_pkg::req_in_t r;
        r = make_offer($urandom, 1'($urandom));
        r.func = tkck_pkg::FuncReport;
        return r;
    endfunction

    // Random distance: mostly below the cutoff, with some at or above it, so both accepts and rejects
    // occur, with some repeats to exercise the after-equals ordering.
    function automatic logic [31:0] random_distance(input logic [31:0] cut);
        case ($urandom_range(9))
            0: return $urandom;
            1: return cut;
            2: return 32'($urandom_range(7)) << 16;
            default: return (cut == 0) ? 32'd0 : 32'($urandom) % cut;
        endcase
    endfunction

    task automatic random_phase(input int count, input logic [31:0] cut);
        tkck_pkg::req_in_t r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 12)
                r = make_report();
            else
                r = make_offer(random_distance(cut), $urandom_range(99) < 8);
            send_request(r);
        end
    endtask

    initial
    begin
        tkck_pkg::req_in_t r;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = tkck_pkg::CfgKeepLimit;
        cfg_data      = '0;
        send_idle_pct = 14;
        recv_idle_pct = 61;
        quiet_cycles  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: an empty report, an exploded offer,
        // the extremes of every field and equal distances.
        send_request(make_report());
        send_request(make_offer(32'd5 << 16, 1'b1));
        r = make_offer(32'd0, 1'b0);
        r.root_length = 16'hFFFF; r.a_insert = '1; r.a_delete = '1;
        r.insert_ratio = '1; r.delete_ratio = '1;
        send_request(r);
        r = make_offer(32'd0, 1'b0);
        r.root_length = '0; r.a_insert = '0; r.a_delete = '0;
        r.insert_ratio = '0; r.delete_ratio = '0;
        send_request(r);
        send_request(make_offer(tkck_pkg::CutoffReset, 1'b0));
        send_request(make_offer(tkck_pkg::CutoffReset - 1, 1'b0));
        send_request(make_offer(32'hFFFF_FFFF, 1'b0));
        send_request(make_report());
        wait_idle();

        // A keep limit of one, then of zero, then above the storage, then lowered below the fill.
        write_register(tkck_pkg::CfgKeepLimit, 32'd1);
        for (int i = 0; i < 4; i++)
            send_request(make_offer(32'(4 - i) << 16, 1'b0));
        send_request(make_report());
        wait_idle();
        write_register(tkck_pkg::CfgKeepLimit, 32'd0);
        write_register(tkck_pkg::CfgInitialCutoff, 32'hFFFF_FFFF);
        send_request(make_offer(32'd9, 1'b0));
        send_request(make_report());
        wait_idle();
        write_register(tkck_pkg::CfgKeepLimit, 32'd127);
        for (int i = 0; i < 8; i++)
            send_request(make_offer(32'd100, 1'b0));
        send_request(make_report());
        wait_idle();
        write_register(tkck_pkg::CfgKeepLimit, 32'd3);
        send_request(make_report());
        send_request(make_offer(32'd50, 1'b0));
        send_request(make_report());
        wait_idle();

        // Random phases with the sender mostly busy and the receiver often stalled.
        write_register(tkck_pkg::CfgKeepLimit, 32'd64);
        write_register(tkck_pkg::CfgInitialCutoff, 32'd0);
        random_phase(60, 32'd1 << 16);
        wait_idle();
        write_register(tkck_pkg::CfgInitialCutoff, tkck_pkg::CutoffReset);
        random_phase(540, tkck_pkg::CutoffReset);
        wait_idle();

        // Roles swapped: the sender idles often and the receiver rarely.
        send_idle_pct = 61;
        recv_idle_pct = 14;
        write_register(tkck_pkg::CfgKeepLimit, 32'($urandom_range(1, 16)));
        write_register(tkck_pkg::CfgInitialCutoff, 32'hFFFF_FFFF);
        random_phase(700, 32'hFFFF_FFFF);
        wait_idle();

        // No idling on either side, with a small limit and a moderate cutoff.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(tkck_pkg::CfgKeepLimit, 32'd5);
        write_register(tkck_pkg::CfgInitialCutoff, 32'd200 << 16);
        random_phase(700, 32'd200 << 16);
        send_request(make_report());
        stop_sending();

        // Wait for the last results, then a short drain for any trailing offer.
        while (pending_reports != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
